// ----- sv/bayer_rggb_demosaic_swap_defines.svh -----
// Assertion macros used by the checker file.
`ifndef BAYER_RGGB_DEMOSAIC_SWAP_DEFINES_SVH
`define BAYER_RGGB_DEMOSAIC_SWAP_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define BDM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define BDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/bdm_pkg.sv -----
package bdm_pkg;

   localparam int PIXEL_W      = 8;
   localparam int SIZE_W       = 13;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 13;

   localparam int MAX_WIDTH_DEFAULT  = 4096;
   localparam int MAX_HEIGHT_DEFAULT = 4096;

   localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWAP_MODE    = 2'd2;

   typedef enum logic [1:0] {
      SWAP_NONE = 2'd0,
      SWAP_RB   = 2'd1,
      SWAP_RG   = 2'd2,
      SWAP_GB   = 2'd3
   } swap_mode_type;

endpackage

// ----- sv/bayer_rggb_demosaic_swap.sv -----
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_raw_pixel
// rsp      out        rsp_valid/rsp_stall  rsp_red, rsp_green, rsp_blue, rsp_frame_last
// csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One pixel per cycle unless stalled; results pass the input and result registers.
// The line buffer RAM is read and written once per transfer (read-first).
// Synchronous reset clears counters and pipeline valids; csr registers get defaults.
// A stalled result holds the pipeline; req_stall rises only then.
module bayer_rggb_demosaic_swap #(
   parameter int MAX_WIDTH  = bdm_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = bdm_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bdm_pkg::PIXEL_W-1:0]       req_raw_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bdm_pkg::PIXEL_W-1:0]       rsp_red,
   output logic [bdm_pkg::PIXEL_W-1:0]       rsp_green,
   output logic [bdm_pkg::PIXEL_W-1:0]       rsp_blue,
   output logic                              rsp_frame_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bdm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bdm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bdm_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [SIZE_W-1:0]  frame_width_ff;
   logic [SIZE_W-1:0]  frame_height_ff;
   swap_mode_type      swap_mode_ff;

   logic [CW-1:0]      col_ff, col_in, col_cur, wlast;
   logic [RW-1:0]      row_ff, row_in, row_cur, hlast;

   logic               s1_valid_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic               s1_emit_ff, s1_last_ff, s1_ti_ff, s1_tj_ff;

   logic [PIXEL_W-1:0] left_ff, upper_left_ff, up;

   logic               rsp_valid_ff;
   logic [PIXEL_W-1:0] red_ff, green_ff, blue_ff;
   logic               last_ff;

   logic               req_xfer, out_free, s1_adv, out_load;
   logic [PIXEL_W-1:0] win_a, win_b, win_c, win_d;
   logic [PIXEL_W-1:0] r_pre, g_pre, b_pre, r_out, g_out, b_out;

   // csr
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         swap_mode_ff    <= SWAP_NONE;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_FRAME_WIDTH) begin
            frame_width_ff <= csr_wdata[SIZE_W-1:0];
         end
         if (csr_index == CSR_FRAME_HEIGHT) begin
            frame_height_ff <= csr_wdata[SIZE_W-1:0];
         end
         if (csr_index == CSR_SWAP_MODE) begin
            swap_mode_ff <= swap_mode_type'(csr_wdata[1:0]);
         end
      end
   end

   // clamped last index of row and frame
   always_comb begin
      if (frame_width_ff < SIZE_W'(2)) begin
         wlast = CW'(1);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         wlast = CW'(MAX_WIDTH - 1);
      end else begin
         wlast = CW'(frame_width_ff - SIZE_W'(1));
      end
      if (frame_height_ff < SIZE_W'(2)) begin
         hlast = RW'(1);
      end else if (32'(frame_height_ff) > 32'(MAX_HEIGHT)) begin
         hlast = RW'(MAX_HEIGHT - 1);
      end else begin
         hlast = RW'(frame_height_ff - SIZE_W'(1));
      end
   end

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && (!s1_emit_ff || out_free);
   assign out_load  = s1_valid_ff && s1_emit_ff && out_free;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_xfer  = req_valid && !req_stall;

   // position counters
   always_comb begin
      col_cur = (col_ff >= wlast) ? wlast : col_ff;
      row_cur = (row_ff >= hlast) ? hlast : row_ff;
      if (col_cur >= wlast) begin
         col_in = '0;
         row_in = (row_cur >= hlast) ? '0 : row_cur + RW'(1);
      end else begin
         col_in = col_cur + CW'(1);
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_xfer) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   bdm_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (req_xfer),
      .wr_addr (col_cur),
      .wr_data (req_raw_pixel),
      .rd_en   (req_xfer),
      .rd_addr (col_cur),
      .rd_data (up)
   );

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_pixel_ff <= req_raw_pixel;
         s1_emit_ff  <= (row_cur != '0) && (col_cur != '0);
         s1_last_ff  <= (row_cur == hlast) && (col_cur == wlast);
         s1_ti_ff    <= !row_cur[0];
         s1_tj_ff    <= !col_cur[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= '0;
         upper_left_ff <= '0;
      end else if (s1_adv) begin
         left_ff       <= s1_pixel_ff;
         upper_left_ff <= up;
      end
   end

   // window and swap
   assign win_a = upper_left_ff;
   assign win_b = up;
   assign win_c = left_ff;
   assign win_d = s1_pixel_ff;

   always_comb begin
      unique case ({s1_ti_ff, s1_tj_ff})
         2'b00: begin
            r_pre = win_a;
            g_pre = (win_b >> 1) + (win_c >> 1);
            b_pre = win_d;
         end
         2'b01: begin
            r_pre = win_b;
            g_pre = (win_a >> 1) + (win_d >> 1);
            b_pre = win_c;
         end
         2'b10: begin
            r_pre = win_c;
            g_pre = (win_a >> 1) + (win_d >> 1);
            b_pre = win_b;
         end
         default: begin
            r_pre = win_d;
            g_pre = (win_b >> 1) + (win_c >> 1);
            b_pre = win_a;
         end
      endcase
      unique case (swap_mode_ff)
         SWAP_RB: begin
            r_out = b_pre;
            g_out = g_pre;
            b_out = r_pre;
         end
         SWAP_RG: begin
            r_out = g_pre;
            g_out = r_pre;
            b_out = b_pre;
         end
         SWAP_GB: begin
            r_out = r_pre;
            g_out = b_pre;
            b_out = g_pre;
         end
         default: begin
            r_out = r_pre;
            g_out = g_pre;
            b_out = b_pre;
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         red_ff   <= r_out;
         green_ff <= g_out;
         blue_ff  <= b_out;
         last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = red_ff;
   assign rsp_green      = green_ff;
   assign rsp_blue       = blue_ff;
   assign rsp_frame_last = last_ff;

endmodule

// ----- sv/bdm_ram.sv -----
module bdm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/bdm_checker.sv -----
`include "bayer_rggb_demosaic_swap_defines.svh"

module bdm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [bdm_pkg::PIXEL_W-1:0] rsp_red,
   input logic [bdm_pkg::PIXEL_W-1:0] rsp_green,
   input logic [bdm_pkg::PIXEL_W-1:0] rsp_blue,
   input logic                        rsp_frame_last
);
   import bdm_pkg::*;

   logic rsp_hold;

   assign rsp_hold = rsp_valid && rsp_stall;

   `BDM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_hold, rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_frame_last), "stalled result changed")
   `BDM_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid, "result valid after reset")
   `BDM_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "request stalled without a held result")
   `BDM_ASSERT_NOW(a_rsp_origin, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "result without a request transfer")

endmodule

bind bayer_rggb_demosaic_swap bdm_checker u_bdm_checker (.*);

// ----- verif/bayer_rggb_demosaic_swap_test.sv -----
module bayer_rggb_demosaic_swap_test;
   import bdm_pkg::*;

   localparam int unsigned LINE_DEPTH = MAX_WIDTH_DEFAULT;
   localparam int unsigned ROW_LIMIT = MAX_HEIGHT_DEFAULT;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [3:0] SET_WIDTH = 4'b0001 << CSR_FRAME_WIDTH;
   localparam logic [3:0] SET_HEIGHT = 4'b0001 << CSR_FRAME_HEIGHT;
   localparam logic [3:0] SET_SWAP = 4'b0001 << CSR_SWAP_MODE;
   localparam logic [3:0] SET_SPARE = 4'b0001 << CSR_SPARE;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned RANDOM_PIXELS = 80;
   localparam int unsigned CLAMP_PIXELS = 32;
   localparam longint unsigned CYCLE_LIMIT = 2_000_000;
   localparam logic [PIXEL_W-1:0] CORNER_PIXELS [9] = '{
      8'd255, 8'd0, 8'd254, 8'd1, 8'd128, 8'd127, 8'd255, 8'd255, 8'd0
   };

   typedef struct packed {
      logic [PIXEL_W-1:0] red;
      logic [PIXEL_W-1:0] green;
      logic [PIXEL_W-1:0] blue;
      logic               frame_last;
   } rgb_pixel_type;

   class demosaic_scoreboard_type;
      logic [PIXEL_W-1:0] line_store [LINE_DEPTH];
      logic [PIXEL_W-1:0] left_pixel;
      logic [PIXEL_W-1:0] upper_left_pixel;
      int unsigned        col_pos;
      int unsigned        row_pos;
      logic [SIZE_W-1:0]  width_reg;
      logic [SIZE_W-1:0]  height_reg;
      swap_mode_type      swap_reg;
      rgb_pixel_type      expected_rgb [$];
      int unsigned        failures;

      function new();
         foreach (line_store[i]) line_store[i] = '0;
         left_pixel = '0;
         upper_left_pixel = '0;
         col_pos = 0;
         row_pos = 0;
         width_reg = FRAME_WIDTH_RESET;
         height_reg = FRAME_HEIGHT_RESET;
         swap_reg = SWAP_NONE;
         failures = 0;
      endfunction

      function int unsigned clamp_dim(logic [SIZE_W-1:0] v, int unsigned hi);
         if (v < 2) return 2;
         if (v > hi) return hi;
         return 32'(v);
      endfunction

      function int unsigned line_width();
         return clamp_dim(width_reg, LINE_DEPTH);
      endfunction

      function int unsigned frame_rows();
         return clamp_dim(height_reg, ROW_LIMIT);
      endfunction

      function bit at_frame_start();
         return col_pos == 0 && row_pos == 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FRAME_WIDTH:  width_reg = data;
            CSR_FRAME_HEIGHT: height_reg = data;
            CSR_SWAP_MODE:    swap_reg = swap_mode_type'(data[1:0]);
            default: ;
         endcase
      endfunction

      function void note_pixel(logic [PIXEL_W-1:0] pix);
         int unsigned        w;
         int unsigned        h;
         int unsigned        c;
         int unsigned        r;
         logic               ti;
         logic               tj;
         logic [PIXEL_W-1:0] ul;
         logic [PIXEL_W-1:0] ur;
         logic [PIXEL_W-1:0] ll;
         logic [PIXEL_W-1:0] red;
         logic [PIXEL_W-1:0] grn;
         logic [PIXEL_W-1:0] blu;
         logic [PIXEL_W-1:0] tmp;
         rgb_pixel_type      want;
         w = line_width();
         h = frame_rows();
         c = (col_pos >= w) ? w - 1 : col_pos;
         r = (row_pos >= h) ? h - 1 : row_pos;
         ur = line_store[c % LINE_DEPTH];
         if (r >= 1 && c >= 1) begin
            ul = upper_left_pixel;
            ll = left_pixel;
            ti = ((r - 1) % 2) != 0;
            tj = ((c - 1) % 2) != 0;
            case ({ti, tj})
               2'b00: begin
                  red = ul; grn = (ur >> 1) + (ll >> 1); blu = pix;
               end
               2'b01: begin
                  red = ur; grn = (ul >> 1) + (pix >> 1); blu = ll;
               end
               2'b10: begin
                  red = ll; grn = (ul >> 1) + (pix >> 1); blu = ur;
               end
               default: begin
                  red = pix; grn = (ur >> 1) + (ll >> 1); blu = ul;
               end
            endcase
            case (swap_reg)
               SWAP_RB: begin
                  tmp = red; red = blu; blu = tmp;
               end
               SWAP_RG: begin
                  tmp = red; red = grn; grn = tmp;
               end
               SWAP_GB: begin
                  tmp = grn; grn = blu; blu = tmp;
               end
               default: ;
            endcase
            want.red = red;
            want.green = grn;
            want.blue = blu;
            want.frame_last = (r == h - 1) && (c == w - 1);
            expected_rgb.push_back(want);
         end
         upper_left_pixel = ur;
         left_pixel = pix;
         line_store[c % LINE_DEPTH] = pix;
         if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
            row_pos = r;
         end
      endfunction

      function void report_field(string field, logic [PIXEL_W-1:0] want,
                                 logic [PIXEL_W-1:0] got);
         if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         end
      endfunction

      function void check_result(rgb_pixel_type got);
         rgb_pixel_type want;
         if (expected_rgb.size() == 0) begin
            failures++;
            $display("%0t: unexpected transfer, expected none, got rgb %0d %0d %0d last %0d",
                     $time, got.red, got.green, got.blue, got.frame_last);
            return;
         end
         want = expected_rgb.pop_front();
         report_field("red", want.red, got.red);
         report_field("green", want.green, got.green);
         report_field("blue", want.blue, got.blue);
         report_field("frame_last", {7'd0, want.frame_last}, {7'd0, got.frame_last});
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_raw_pixel;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [PIXEL_W-1:0]     rsp_red;
   logic [PIXEL_W-1:0]     rsp_green;
   logic [PIXEL_W-1:0]     rsp_blue;
   logic                   rsp_frame_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   demosaic_scoreboard_type sb;
   int unsigned             req_gap_max;
   int unsigned             rsp_gap_max;
   bit                      hold_request;
   longint unsigned         cycle_count;

   bayer_rggb_demosaic_swap dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_raw_pixel(req_raw_pixel),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_red(rsp_red),
      .rsp_green(rsp_green),
      .rsp_blue(rsp_blue),
      .rsp_frame_last(rsp_frame_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bayer_rggb_demosaic_swap verification failed");
         $finish;
      end
   end

   function automatic logic [PIXEL_W-1:0] draw_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIXEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] pick_width();
      case ($urandom_range(0, 9))
         0: return SIZE_W'($urandom_range(0, 1));
         1: return SIZE_W'($urandom_range(17, 64));
         default: return SIZE_W'($urandom_range(2, 16));
      endcase
   endfunction

   function automatic int unsigned pick_gap();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 4;
         default: return 16;
      endcase
   endfunction

   // enter and leave at a falling edge
   task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_raw_pixel <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_pixel(pix);
      @(negedge clock);
   endtask

   task automatic finish_frame();
      while (!sb.at_frame_start()) send_pixel(draw_pixel());
   endtask

   // drop valid, drain every pending result, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_rgb.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_regs(input logic [3:0] mask, input logic [SIZE_W-1:0] width_val,
                               input logic [SIZE_W-1:0] height_val,
                               input logic [CSR_DATA_W-1:0] swap_word);
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  data;
      for (int i = 0; i < 4; i++) begin
         idx = CSR_INDEX_W'(i);
         if (mask[i]) begin
            case (idx)
               CSR_FRAME_WIDTH:  data = width_val;
               CSR_FRAME_HEIGHT: data = height_val;
               CSR_SWAP_MODE:    data = swap_word;
               default:          data = CSR_DATA_W'($urandom_range(0, 8191));
            endcase
            csr_valid <= 1'b1;
            csr_index <= idx;
            csr_wdata <= data;
            @(posedge clock);
            while (!csr_ready) @(posedge clock);
            sb.write_reg(idx, data);
            @(negedge clock);
         end
      end
      csr_valid <= 1'b0;
   endtask

   initial begin : result_sink
      int unsigned   hold;
      rgb_pixel_type got;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold = LONG_HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            hold = $urandom_range(0, rsp_gap_max);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.red = rsp_red;
         got.green = rsp_green;
         got.blue = rsp_blue;
         got.frame_last = rsp_frame_last;
         sb.check_result(got);
      end
   end

   initial begin : stimulus
      int unsigned       random_count;
      int unsigned       burst;
      logic [SIZE_W-1:0] new_w;
      logic [SIZE_W-1:0] new_h;
      reset = 1'b1;
      req_valid = 1'b0;
      req_raw_pixel = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      hold_request = 1'b0;
      req_gap_max = 1;
      rsp_gap_max = 1;
      random_count = 0;
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset configuration: one full default row and the start of the next
      repeat (FRAME_WIDTH_RESET + 3) send_pixel(draw_pixel());
      settle();
      // shrink the frame mid-row so both counters wrap
      program_regs(SET_WIDTH | SET_HEIGHT, 13'd3, 13'd3, '0);
      finish_frame();
      req_gap_max = 16;
      rsp_gap_max = 16;
      foreach (CORNER_PIXELS[i]) send_pixel(CORNER_PIXELS[i]);

      settle();
      program_regs(SET_WIDTH | SET_HEIGHT | SET_SWAP | SET_SPARE, 13'd2, 13'd2,
                   {11'h7FF, SWAP_RB});
      repeat (4) send_pixel(draw_pixel());
      settle();
      program_regs(SET_SWAP, '0, '0, {11'h000, SWAP_RG});
      repeat (4) send_pixel(draw_pixel());
      settle();
      program_regs(SET_SWAP, '0, '0, {11'h555, SWAP_GB});
      repeat (4) send_pixel(draw_pixel());

      // out-of-range sizes clamp to the widest, narrowest, tallest and shortest frames
      settle();
      req_gap_max = 2;
      rsp_gap_max = 2;
      program_regs(SET_WIDTH | SET_HEIGHT | SET_SWAP, 13'h1FFF, 13'd1, {11'h000, SWAP_NONE});
      repeat (CLAMP_PIXELS) send_pixel(draw_pixel());
      settle();
      program_regs(SET_WIDTH | SET_HEIGHT, 13'd0, 13'h1FFF, '0);
      repeat (CLAMP_PIXELS) send_pixel(draw_pixel());

      // hold the result side off while pixels keep coming
      settle();
      req_gap_max = 0;
      rsp_gap_max = 0;
      program_regs(SET_WIDTH | SET_HEIGHT, 13'd8, 13'd8, '0);
      hold_request = 1'b1;
      repeat (64) send_pixel(draw_pixel());

      while (random_count < RANDOM_PIXELS) begin
         settle();
         req_gap_max = pick_gap();
         rsp_gap_max = pick_gap();
         // widen only at a frame boundary so the line buffer row above is always written
         if (sb.at_frame_start())
            new_w = pick_width();
         else
            new_w = SIZE_W'($urandom_range(0, sb.line_width()));
         new_h = SIZE_W'($urandom_range(0, 9));
         program_regs(4'($urandom_range(1, 7)), new_w, new_h,
                      CSR_DATA_W'($urandom_range(0, 8191)));
         burst = $urandom_range(10, 120);
         repeat (burst) send_pixel(draw_pixel());
         random_count += burst;
         if ($urandom_range(0, 1) == 1) finish_frame();
      end

      settle();
      if (sb.failures == 0 && sb.expected_rgb.size() == 0)
         $display("bayer_rggb_demosaic_swap verification clean");
      else
         $display("bayer_rggb_demosaic_swap verification failed");
      $finish;
   end

endmodule
